// ===== src/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg: shared constants and types of the polyphase rational resampler
// Holds the sizing constants, the register index codes and the control state
// encoding used across the resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package prr_pkg;

    localparam int COEF_DEPTH  = 16384;
    localparam int HIST_DEPTH  = 512;
    localparam int SAMPLE_BITS = 24;

    localparam int COEF_BITS   = 24;
    localparam int FACTOR_BITS = 12;
    localparam int TAPS_BITS   = 15;
    localparam int PHASE_BITS  = 13;
    localparam int INDEX_BITS  = 14;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 15;
    localparam int RUN_LIMIT   = 64;
    localparam int RUN_BITS    = 6;
    localparam int ACC_BITS    = 64;
    localparam int ROUND_SHIFT = 22;

    localparam int COEF_ABITS = $clog2(COEF_DEPTH);
    localparam int HIST_ABITS = $clog2(HIST_DEPTH);
    localparam int FILL_BITS  = $clog2(HIST_DEPTH + 1);
    localparam int TAP_CNT_BITS = $clog2(COEF_DEPTH + 4096);
    localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_UP_FACTOR   = 2'd0,
        REG_DOWN_FACTOR = 2'd1,
        REG_TAP_COUNT   = 2'd2,
        REG_NONE        = 2'd3
    } cfg_reg_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_MAC   = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_SKIP  = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// ===== src/prr_ram.sv =====
// ----------------------------------------------------------------------------
// prr_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/polyphase_rational_resampler.sv =====
// ----------------------------------------------------------------------------
// polyphase_rational_resampler: L/M polyphase FIR sample-rate converter
// Coefficient and history memories walked by one shared multiply-accumulate.
// ----------------------------------------------------------------------------
// A request with op=1 writes one coefficient. A request with op=0 stores the
// sample and then produces every output that falls in its L-slot, at most 64.
// Each output sums T taps, where T is the number of taps used (at most
// ceil((tap_count-offset)/L), bounded by the number of samples held), in a
// single tap walk through the coefficient and history RAMs, one tap per cycle.
// A cut run then steps the phase by M once a cycle to the end of the slot.
// History reset is handled by a fill count, so no clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphase_rational_resampler
    import prr_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic        [INDEX_BITS-1:0]  coef_index,
    input  wire logic signed [COEF_BITS-1:0]   coef_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      resampled,
    output logic                               last,
    output logic                               clipped,
    output logic                               run_cut,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

    localparam logic signed [ACC_BITS-1:0] SAT_MAX =
        (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - 64'sd1;
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = 64'sd1 <<< (ROUND_SHIFT - 1);

    state_t state_reg, state_next;

    logic [FACTOR_BITS-1:0] up_reg, down_reg;
    logic [TAPS_BITS-1:0]   taps_reg;
    logic [HIST_ABITS-1:0]  wp_reg, rp_reg;
    logic [FILL_BITS-1:0]   fill_reg, d_reg;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [RUN_BITS-1:0]    n_reg;
    logic [TAP_CNT_BITS-1:0] c_reg;
    logic                   v1_reg, v2_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;

    logic                   out_valid_reg, last_reg, clipped_reg, run_cut_reg;
    logic signed [SAMPLE_BITS-1:0] resampled_reg;

    logic [FACTOR_BITS-1:0] l_eff, m_eff;
    logic [31:0]            k_eff;
    logic                   issue, drained, emit, in_fire;
    logic [PHASE_BITS:0]    phase_step;
    logic                   is_last, is_cut;
    logic signed [ACC_BITS-1:0] rounded, quot;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic                   sat_flag;
    logic [HIST_ABITS-1:0]  newest;

    logic                   coef_we, hist_we;
    logic [COEF_ABITS-1:0]  coef_waddr;
    logic [COEF_BITS-1:0]   coef_rdata;
    logic [SAMPLE_BITS-1:0] hist_rdata;

    assign l_eff = (up_reg == '0) ? FACTOR_BITS'(1) : up_reg;
    assign m_eff = (down_reg == '0) ? FACTOR_BITS'(1) : down_reg;
    assign k_eff = (32'(taps_reg) > 32'(COEF_DEPTH)) ? 32'(COEF_DEPTH) : 32'(taps_reg);

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign coef_we    = in_fire && op && (32'(coef_index) < 32'(COEF_DEPTH));
    assign coef_waddr = COEF_ABITS'(coef_index);
    assign hist_we    = in_fire && !op;

    assign newest = (wp_reg == '0) ? HIST_ABITS'(HIST_DEPTH - 1) : wp_reg - 1'b1;

    assign issue   = (state_reg == ST_MAC) && (32'(c_reg) < k_eff) && (d_reg < fill_reg);
    assign drained = !issue && !v1_reg && !v2_reg;

    assign phase_step = {1'b0, phase_reg} + (PHASE_BITS + 1)'(m_eff);
    assign is_cut  = (n_reg == RUN_BITS'(RUN_LIMIT - 1)) && (phase_step < (PHASE_BITS + 1)'(l_eff));
    assign is_last = (phase_step >= (PHASE_BITS + 1)'(l_eff)) || is_cut;
    assign emit    = (state_reg == ST_ROUND) && (!out_valid_reg || out_ready);

    always_comb
    begin
        rounded  = acc_reg + ROUND_HALF;
        quot     = rounded >>> ROUND_SHIFT;
        sat_flag = 1'b0;
        sat_val  = SAMPLE_BITS'(quot);
        if (quot > SAT_MAX)
        begin
            sat_val  = SAMPLE_BITS'(SAT_MAX);
            sat_flag = 1'b1;
        end
        else if (quot < SAT_MIN)
        begin
            sat_val  = SAMPLE_BITS'(SAT_MIN);
            sat_flag = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && !op)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (phase_reg < PHASE_BITS'(l_eff))
                begin
                    state_next = ST_MAC;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_MAC:
            begin
                if (drained)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (emit)
                begin
                    priority if (is_cut)
                    begin
                        state_next = ST_SKIP;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_SKIP:
            begin
                if (phase_reg >= PHASE_BITS'(l_eff))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            up_reg        <= FACTOR_BITS'(1);
            down_reg      <= FACTOR_BITS'(1);
            taps_reg      <= TAPS_BITS'(1);
            wp_reg        <= '0;
            fill_reg      <= '0;
            phase_reg     <= '0;
            n_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_UP_FACTOR:   up_reg   <= cfg_data[FACTOR_BITS-1:0];
                    REG_DOWN_FACTOR: down_reg <= cfg_data[FACTOR_BITS-1:0];
                    REG_TAP_COUNT:   taps_reg <= cfg_data[TAPS_BITS-1:0];
                    REG_NONE:        ;
                    default:         ;
                endcase
            end

            if (hist_we)
            begin
                wp_reg <= (wp_reg == HIST_ABITS'(HIST_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                if (fill_reg != FILL_BITS'(HIST_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                n_reg <= '0;
            end

            v1_reg <= issue;
            v2_reg <= v1_reg;

            if (emit)
            begin
                n_reg     <= n_reg + 1'b1;
                phase_reg <= PHASE_BITS'(phase_step);
            end
            else if (state_reg == ST_SKIP && phase_reg < PHASE_BITS'(l_eff))
            begin
                phase_reg <= PHASE_BITS'(phase_step);
            end
            else if (state_reg == ST_FIN)
            begin
                phase_reg <= (phase_reg >= PHASE_BITS'(l_eff))
                             ? phase_reg - PHASE_BITS'(l_eff) : '0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_START)
        begin
            c_reg   <= TAP_CNT_BITS'(phase_reg);
            d_reg   <= '0;
            rp_reg  <= newest;
            acc_reg <= '0;
        end
        else
        begin
            if (issue)
            begin
                c_reg  <= c_reg + TAP_CNT_BITS'(l_eff);
                d_reg  <= d_reg + 1'b1;
                rp_reg <= (rp_reg == '0) ? HIST_ABITS'(HIST_DEPTH - 1) : rp_reg - 1'b1;
            end
            if (v2_reg)
            begin
                acc_reg <= acc_reg + ACC_BITS'(prod_reg);
            end
        end
        if (v1_reg)
        begin
            prod_reg <= $signed(hist_rdata) * $signed(coef_rdata);
        end
        if (emit)
        begin
            resampled_reg <= sat_val;
            clipped_reg   <= sat_flag;
            last_reg      <= is_last;
            run_cut_reg   <= is_cut;
        end
    end

    prr_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_value),
        .raddr (c_reg[COEF_ABITS-1:0]),
        .rdata (coef_rdata)
    );

    prr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_reg),
        .wdata (sample),
        .raddr (rp_reg),
        .rdata (hist_rdata)
    );

    assign out_valid = out_valid_reg;
    assign resampled = resampled_reg;
    assign last      = last_reg;
    assign clipped   = clipped_reg;
    assign run_cut   = run_cut_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_BITS'(HIST_DEPTH))
        else $error("history fill count out of range");

    a_walk_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (d_reg <= fill_reg))
        else $error("tap walk passed the stored history");

    a_cut_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && run_cut_reg |-> last_reg)
        else $error("cut run output not marked last");

    a_mac_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> $past(v1_reg))
        else $error("accumulate without a product");

    a_emit_from_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (!v1_reg && !v2_reg))
        else $error("rounding before accumulation finished");

endmodule

`default_nettype wire

// ===== bench/polyphase_rational_resampler_checker.sv =====
// ----------------------------------------------------------------------------
// polyphase_rational_resampler_checker: output predictor and scoreboard
// Watches the request, result and register write ports of the resampler and
// keeps its own copy of the history, coefficient memory and phase. Each
// accepted sample request queues the outputs of its L-slot. Each accepted
// output is compared field by field with the oldest queued output.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphase_rational_resampler_checker
    import prr_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          op,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic        [INDEX_BITS-1:0]  coef_index,
    input  wire logic signed [COEF_BITS-1:0]   coef_value,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] resampled,
    input  wire logic                          last,
    input  wire logic                          clipped,
    input  wire logic                          run_cut,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
    output int                                 pending,
    output int                                 failures
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] resampled;
        logic                          last;
        logic                          clipped;
        logic                          run_cut;
    } out_sample_t;

    out_sample_t                   out_fifo[$];
    logic signed [SAMPLE_BITS-1:0] hist_mem[HIST_DEPTH];
    logic signed [COEF_BITS-1:0]   taps_mem[COEF_DEPTH];
    logic [HIST_ABITS-1:0]         hist_wr;
    logic [PHASE_BITS-1:0]         slot_phase;
    logic [FACTOR_BITS-1:0]        up_l;
    logic [FACTOR_BITS-1:0]        down_m;
    logic [TAPS_BITS-1:0]          taps_k;

    assign pending = out_fifo.size();

    function automatic out_sample_t filter_point(int off, int l_eff, int k_eff);
        out_sample_t o;
        longint      acc;
        longint      q;
        int          c;
        int          d;
        int          newest;
        acc = 0;
        c = off;
        d = 0;
        newest = (int'(hist_wr) + HIST_DEPTH - 1) % HIST_DEPTH;
        while (c < k_eff && d < HIST_DEPTH) begin
            acc += longint'(hist_mem[(newest + HIST_DEPTH - d) % HIST_DEPTH])
                 * longint'(taps_mem[c]);
            c += l_eff;
            d++;
        end
        q = (acc + (64'sd1 << 21)) >>> ROUND_SHIFT;
        o.clipped = 1'b0;
        if (q > 64'sd8388607) begin
            q = 64'sd8388607;
            o.clipped = 1'b1;
        end
        if (q < -64'sd8388608) begin
            q = -64'sd8388608;
            o.clipped = 1'b1;
        end
        o.resampled = q[SAMPLE_BITS-1:0];
        o.last = 1'b0;
        o.run_cut = 1'b0;
        return o;
    endfunction

    task automatic push_sample(logic signed [SAMPLE_BITS-1:0] x);
        out_sample_t run[$];
        out_sample_t o;
        int          l_eff;
        int          m_eff;
        int          k_eff;
        int          ph;
        l_eff = (up_l == 0) ? 1 : int'(up_l);
        m_eff = (down_m == 0) ? 1 : int'(down_m);
        k_eff = (taps_k > COEF_DEPTH) ? COEF_DEPTH : int'(taps_k);
        hist_mem[hist_wr] = x;
        hist_wr = hist_wr + 1'b1;
        ph = int'(slot_phase);
        while (ph < l_eff && run.size() < RUN_LIMIT) begin
            run.push_back(filter_point(ph, l_eff, k_eff));
            ph += m_eff;
        end
        if (ph < l_eff) begin
            ph += ((l_eff - ph + m_eff - 1) / m_eff) * m_eff;
            run[run.size()-1].run_cut = 1'b1;
        end
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        ph = (ph >= l_eff) ? ph - l_eff : 0;
        slot_phase = ph[PHASE_BITS-1:0];
        foreach (run[i])
            out_fifo.push_back(run[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_sample_t exp_o;
        if (!rst_n)
        begin
            out_fifo.delete();
            foreach (hist_mem[i])
                hist_mem[i] = '0;
            hist_wr = '0;
            slot_phase = '0;
            up_l = FACTOR_BITS'(1);
            down_m = FACTOR_BITS'(1);
            taps_k = TAPS_BITS'(1);
            failures = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (out_fifo.size() == 0)
                begin
                    $error("unexpected output resampled=%0d", resampled);
                    failures++;
                end
                else
                begin
                    exp_o = out_fifo.pop_front();
                    if (resampled !== exp_o.resampled)
                    begin
                        $error("resampled: expected %0d, got %0d", exp_o.resampled,
                               resampled);
                        failures++;
                    end
                    if (last !== exp_o.last)
                    begin
                        $error("last: expected %0b, got %0b", exp_o.last, last);
                        failures++;
                    end
                    if (clipped !== exp_o.clipped)
                    begin
                        $error("clipped: expected %0b, got %0b", exp_o.clipped, clipped);
                        failures++;
                    end
                    if (run_cut !== exp_o.run_cut)
                    begin
                        $error("run_cut: expected %0b, got %0b", exp_o.run_cut, run_cut);
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (op)
                begin
                    if (coef_index < COEF_DEPTH)
                        taps_mem[coef_index] = coef_value;
                end
                else
                    push_sample(sample);
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_UP_FACTOR:   up_l = cfg_data[FACTOR_BITS-1:0];
                    REG_DOWN_FACTOR: down_m = cfg_data[FACTOR_BITS-1:0];
                    REG_TAP_COUNT:   taps_k = cfg_data[TAPS_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== bench/polyphase_rational_resampler_tb.sv =====
// ----------------------------------------------------------------------------
// polyphase_rational_resampler_tb: stimulus and verdict for the resampler
// Fills the low coefficients, then runs directed corner cases (extreme
// samples, clipping, cut runs, empty slots, zero factors, oversized tap
// counts) and random phases under random stalls on both sides. Checking is
// done by the checker instance.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphase_rational_resampler_tb
    import prr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 4400;
    localparam int COEF_FILL = 160;
    localparam int TAP_LIMIT = 128;
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic        [INDEX_BITS-1:0]  coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [SAMPLE_BITS-1:0] resampled;
    logic                          last;
    logic                          clipped;
    logic                          run_cut;
    logic                          cfg_we;
    logic [CFG_IDX_BITS-1:0]       cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;
    int                            pending;
    int                            failures;
    longint                        cycles;
    bit                            no_gaps;
    bit                            burst_in;
    bit                            burst_out;

    polyphase_rational_resampler dut (.*);
    polyphase_rational_resampler_checker scoreboard (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("polyphase_rational_resampler_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        burst_out = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 15) == 0)
                burst_out = ~burst_out;
            stall = burst_out ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_req(logic o, logic signed [SAMPLE_BITS-1:0] s,
                            logic [INDEX_BITS-1:0] ci, logic signed [COEF_BITS-1:0] cv);
        int gap;
        if ($urandom_range(0, 15) == 0)
            burst_in = ~burst_in;
        gap = (no_gaps || burst_in) ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op = o;
        sample = s;
        coef_index = ci;
        coef_value = cv;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s);
        send_req(1'b0, s, INDEX_BITS'($urandom), COEF_BITS'($urandom));
    endtask

    task automatic send_coef(logic [INDEX_BITS-1:0] ci, logic signed [COEF_BITS-1:0] cv);
        send_req(1'b1, SAMPLE_BITS'($urandom), ci, cv);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_rates(int l, int m, int k);
        drain();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = REG_UP_FACTOR;
        cfg_data = CFG_DATA_BITS'(l);
        @(negedge clk);
        cfg_index = REG_DOWN_FACTOR;
        cfg_data = CFG_DATA_BITS'(m);
        @(negedge clk);
        cfg_index = REG_TAP_COUNT;
        cfg_data = CFG_DATA_BITS'(k);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return SAMPLE_BITS'($urandom_range(0, 255) - 128);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEF_BITS-1:0] rand_coef();
        if ($urandom_range(0, 9) == 0)
            return COEF_BITS'($urandom);
        return COEF_BITS'($urandom_range(0, 1 << 19) - (1 << 18));
    endfunction

    initial
    begin
        int l;
        int m;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = 1'b0;
        sample = '0;
        coef_index = '0;
        coef_value = '0;
        cfg_we = 1'b0;
        cfg_index = REG_NONE;
        cfg_data = '0;
        no_gaps = 1'b1;
        burst_in = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every tap the walks below can reach
        for (int i = 0; i < COEF_FILL; i++)
            send_coef(INDEX_BITS'(i), rand_coef());
        no_gaps = 1'b0;

        send_coef(INDEX_BITS'(0), 24'sh7FFFFF);
        send_sample(24'sh7FFFFF);
        send_sample(24'sh800000);
        send_coef(INDEX_BITS'(0), 24'sh800000);
        send_sample(24'sh7FFFFF);
        send_sample(24'sh800000);
        send_coef(INDEX_BITS'(COEF_DEPTH - 1), 24'sh7FFFFF);
        send_coef(INDEX_BITS'(1), rand_coef());

        set_rates(3, 2, 24);
        send_sample(24'sh7FFFFF);
        send_sample(24'sh800000);
        send_sample('0);
        send_sample(SAMPLE_BITS'(-1));
        send_sample(SAMPLE_BITS'(1));

        set_rates(4095, 1, 64);
        send_sample(rand_sample());
        send_sample(rand_sample());

        set_rates(1, 4095, 8);
        repeat (3) send_sample(rand_sample());

        set_rates(0, 0, 0);
        repeat (3) send_sample(rand_sample());

        set_rates(7, 5, 32767);
        repeat (3) send_sample(rand_sample());

        set_rates(4095, 4095, 64);
        repeat (3) send_sample(rand_sample());

        for (int p = 0; p < 5; p++)
        begin
            l = $urandom_range(1, 12);
            m = $urandom_range(1, 12);
            set_rates(l, m, $urandom_range(1, (l * 40 < TAP_LIMIT) ? l * 40 : TAP_LIMIT));
            for (int i = 0; i < 40; i++)
            begin
                if (i == 20)
                begin
                    @(negedge clk);
                    in_valid = 1'b0;
                    while (pending != 0) @(posedge clk);
                end
                if ($urandom_range(0, 99) < 15)
                    send_coef(INDEX_BITS'($urandom_range(0, COEF_DEPTH - 1)), rand_coef());
                else
                    send_sample(rand_sample());
            end
        end

        // long walks over the newest TAP_LIMIT held samples
        set_rates(1, 1, TAP_LIMIT);
        repeat (20) send_sample(rand_sample());

        drain();
        if (failures == 0)
            $display("polyphase_rational_resampler_tb: clean");
        else
            $display("polyphase_rational_resampler_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
